// ===== design/text_console_writer_core_macros.svh =====
// assertion macros shared by the console writer rtl
// expects clk and arst_n in the scope of each use
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
// shared constants and codes for the text console writer
// no dependencies
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	// cell store addressing and cursor widths
	localparam int ADDR_W = $clog2(CELLS);
	localparam int POS_W  = $clog2(CELLS + COLUMNS);
	localparam int COL_W  = $clog2(COLUMNS);

	// one cell: attribute in the high byte, character in the low byte
	localparam int CELL_W = 16;

	localparam logic [7:0] BLANK_ATTR_RESET = 8'h0A;
	localparam logic [7:0] TEXT_ATTR_RESET  = 8'h0F;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_RAW   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic {
		REG_TEXT_ATTR  = 1'b0,
		REG_BLANK_ATTR = 1'b1
	} reg_idx_t;

	// where a bulk write takes its data from
	typedef enum logic [1:0] {
		SRC_COPY  = 2'd0,
		SRC_BLANK = 2'd1,
		SRC_INIT  = 2'd2
	} wr_src_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		wr_src_t           src;
	} bulk_wr_t;

endpackage

// ===== design/tcw_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/text_console_writer_core.sv =====
// text console writer top level: cursor logic, bulk sequencer, output register
// depends on tcw_pkg, tcw_ram and text_console_writer_core_macros.svh
//
// channel  | dir | beat fields (lowest bit first)
// s_*      | in  | mode[1:0] char_code[9:2] cell_index[20:10]
// m_*      | out | cursor_pos[10:0] read_char[18:11] read_attr[26:19] scrolled[27]
// cfg_*    | in  | cfg_index selects text_attr / blank_attr, cfg_data is the byte
//
// put and raw beats go on to ST_RESULT; a cell read first passes ST_READ (ram read)
// a scroll or a clear walks the whole store, one cell a cycle, at a rate set by the
// single write port of the cell ram
// after reset a clearing pass over every cell runs before s_tready rises
// one item is in flight; the output register lets the next beat in while a
// result waits on m_tready
`include "text_console_writer_core_macros.svh"

module text_console_writer_core
	import tcw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input beats
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // mode, char_code, cell_index
	// result beats
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // cursor_pos, read_char, read_attr, scrolled
	// register writes
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_READ,
		ST_RESULT
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0] text_attr_q;
	logic [7:0] blank_attr_q;

	// cursor kept as cell index plus column, so no modulo is needed
	logic [POS_W-1:0]  cursor_q;
	logic [COL_W-1:0]  col_q;

	// bulk sequencer pointer and the delayed write stage
	logic [ADDR_W-1:0] ptr_q;
	bulk_wr_t          wr_s1;

	// result holding registers
	logic [7:0] res_char_q;
	logic [7:0] res_attr_q;
	logic       scrolled_q;

	// output register
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	// input beat fields
	mode_t       in_mode;
	logic [7:0]  in_char;
	logic [10:0] in_idx;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// cursor step
	logic             accept;
	logic             printable;
	logic             char_write;
	logic [POS_W-1:0] next_cursor;
	logic [COL_W-1:0] next_col;
	logic             need_scroll;
	logic             idx_in_range;

	assign in_mode = mode_t'(s_tdata[1:0]);
	assign in_char = s_tdata[9:2];
	assign in_idx  = s_tdata[20:10];

	assign s_tready = (state_q == ST_IDLE) && !wr_s1.valid;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign printable    = (in_char >= CH_SPACE) && (in_char <= CH_TILDE);
	assign char_write   = (in_mode == MODE_RAW) || ((in_mode == MODE_PUT) && printable);
	assign idx_in_range = ({21'd0, in_idx} < 32'(CELLS));

	// next cursor for put and raw beats
	always_comb begin
		next_cursor = cursor_q;
		next_col    = col_q;
		if (char_write) begin
			next_cursor = cursor_q + POS_W'(1);
			next_col    = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
		end else if (in_char == CH_LF) begin
			// jump to the start of the next row
			next_cursor = cursor_q + (POS_W'(COLUMNS) - POS_W'(col_q));
			next_col    = '0;
		end else if (in_char == CH_CR) begin
			next_cursor = cursor_q + POS_W'(COLUMNS);
		end
	end

	assign need_scroll = (next_cursor >= POS_W'(CELLS));

	// ram write select: a pending bulk write always wins, a char write only
	// happens in idle, where no bulk write is pending
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(cursor_q);
		ram_wdata = {text_attr_q, in_char};
		if (wr_s1.valid) begin
			ram_we    = 1'b1;
			ram_waddr = wr_s1.addr;
			unique case (wr_s1.src)
				SRC_COPY:  ram_wdata = ram_rdata;
				SRC_BLANK: ram_wdata = {blank_attr_q, 8'h00};
				SRC_INIT:  ram_wdata = {BLANK_ATTR_RESET, 8'h00};
				default:   ram_wdata = {BLANK_ATTR_RESET, 8'h00};
			endcase
		end else if (accept && char_write) begin
			ram_we = 1'b1;
		end
	end

	// scroll reads the row below the cell that gets written in the next cycle
	assign ram_raddr = (state_q == ST_SCROLL) ? ptr_q + ADDR_W'(COLUMNS) : ADDR_W'(in_idx);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// register writes, taken in any state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q  <= TEXT_ATTR_RESET;
			blank_attr_q <= BLANK_ATTR_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TEXT_ATTR:  text_attr_q  <= cfg_data;
				REG_BLANK_ATTR: blank_attr_q <= cfg_data;
				default:        text_attr_q  <= text_attr_q;
			endcase
		end
	end

	// main sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cursor_q   <= '0;
			col_q      <= '0;
			ptr_q      <= '0;
			wr_s1      <= '0;
			res_char_q <= '0;
			res_attr_q <= '0;
			scrolled_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			wr_s1.valid <= 1'b0;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					// reset clearing pass
					wr_s1 <= '{valid: 1'b1, addr: ptr_q, src: SRC_INIT};
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_char_q <= '0;
						res_attr_q <= '0;
						scrolled_q <= 1'b0;
						unique case (in_mode)
							MODE_PUT, MODE_RAW: begin
								col_q <= next_col;
								if (need_scroll) begin
									cursor_q   <= next_cursor - POS_W'(COLUMNS);
									scrolled_q <= 1'b1;
									ptr_q      <= '0;
									state_q    <= ST_SCROLL;
								end else begin
									cursor_q <= next_cursor;
									state_q  <= ST_RESULT;
								end
							end
							MODE_CLEAR: begin
								cursor_q <= '0;
								col_q    <= '0;
								ptr_q    <= '0;
								state_q  <= ST_BLANK;
							end
							MODE_READ: begin
								state_q <= idx_in_range ? ST_READ : ST_RESULT;
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_SCROLL: begin
					// move each cell up one row, write lands next cycle
					wr_s1 <= '{valid: 1'b1, addr: ptr_q, src: SRC_COPY};
					if (ptr_q == ADDR_W'(CELLS - COLUMNS - 1)) begin
						ptr_q   <= ADDR_W'(CELLS - COLUMNS);
						state_q <= ST_BLANK;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_BLANK: begin
					// blank from ptr to the last cell
					wr_s1 <= '{valid: 1'b1, addr: ptr_q, src: SRC_BLANK};
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_RESULT;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_READ: begin
					res_char_q <= ram_rdata[7:0];
					res_attr_q <= ram_rdata[15:8];
					state_q    <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'd0, scrolled_q, res_attr_q, res_char_q,
							11'(cursor_q)};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	`TCW_ASSERT_NOW(a_cursor_range, state_q == ST_IDLE, cursor_q < POS_W'(CELLS), "cursor out of range")
	`TCW_ASSERT_NOW(a_copy_no_overlap, wr_s1.valid && state_q == ST_SCROLL, wr_s1.addr != ram_raddr, "scroll write hits read cell")
	`TCW_ASSERT_NEXT(a_clear_start, accept && in_mode == MODE_CLEAR, state_q == ST_BLANK && ptr_q == '0 && cursor_q == '0, "clear did not start at cell zero")
	`TCW_ASSERT_NOW(a_scroll_cursor, state_q == ST_RESULT && scrolled_q, cursor_q >= POS_W'(CELLS - COLUMNS), "scroll left cursor above last row")

endmodule

// ===== test/text_console_writer_core_test.sv =====
// self-checking testbench for text_console_writer_core: directed table, then random phases
// depends on tcw_pkg and the console writer rtl; predicts every result beat in place
`timescale 1ns / 100ps

module text_console_writer_core_test;
	import tcw_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;   // idle cycles
	localparam int PHASE_BEATS    = 370;     // random beats per register setting
	localparam int PHASES         = 4;
	localparam int REPORT_MAX     = 10;

	// input beat, lowest field in the lowest bits
	typedef struct packed {
		logic [10:0] cell_index;
		logic [7:0]  char_code;
		mode_t       mode;
	} console_cmd_t;

	// result beat, lowest field in the lowest bits
	typedef struct packed {
		logic        scrolled;
		logic [7:0]  read_attr;
		logic [7:0]  read_char;
		logic [10:0] cursor_pos;
	} console_result_t;

	// one directed row: the command, and a typed result where it is obvious
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  ch;
		logic [10:0] idx;
		logic        typed;
		logic [10:0] cur;
		logic [7:0]  rch;
		logic [7:0]  rat;
		logic        scr;
	} plan_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // mode, char_code, cell_index
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // cursor_pos, read_char, read_attr, scrolled
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data  = '0;

	text_console_writer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the screen, the cursor and the two attribute registers
	logic [7:0] screen_char [CELLS];
	logic [7:0] screen_attr [CELLS];
	int         cursor_now;
	logic [7:0] attr_text;
	logic [7:0] attr_blank;

	console_result_t pending_results [$];

	int mismatches  = 0;
	int beats_in    = 0;
	int beats_out   = 0;
	int scroll_count = 0;
	int clear_count = 0;
	int read_count  = 0;
	int send_calm   = 0;   // beats left in a no-gap stretch on the input side

	// directed part: extremes of every field, every mode, ignored bytes,
	// out-of-range reads, newline and carriage return, clear and re-read
	plan_row_t directed_plan [24] = '{
		'{MODE_READ,  8'h00, 11'd0,    1'b1, 11'd0,   8'h00, 8'h0A, 1'b0},
		'{MODE_READ,  8'hFF, 11'd1999, 1'b1, 11'd0,   8'h00, 8'h0A, 1'b0},
		'{MODE_READ,  8'h00, 11'd2047, 1'b1, 11'd0,   8'h00, 8'h00, 1'b0},
		'{MODE_READ,  8'h00, 11'd2000, 1'b1, 11'd0,   8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h20, 11'd2047, 1'b1, 11'd1,   8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h7E, 11'd0,    1'b1, 11'd2,   8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h1F, 11'd0,    1'b1, 11'd2,   8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h7F, 11'd0,    1'b1, 11'd2,   8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'hFF, 11'd0,    1'b1, 11'd2,   8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h00, 11'd0,    1'b1, 11'd2,   8'h00, 8'h00, 1'b0},
		'{MODE_RAW,   8'h00, 11'd0,    1'b1, 11'd3,   8'h00, 8'h00, 1'b0},
		'{MODE_RAW,   8'hFF, 11'h555,  1'b1, 11'd4,   8'h00, 8'h00, 1'b0},
		'{MODE_RAW,   8'h0A, 11'h2AA,  1'b1, 11'd5,   8'h00, 8'h00, 1'b0},
		'{MODE_READ,  8'h00, 11'd1,    1'b1, 11'd5,   8'h7E, 8'h0F, 1'b0},
		'{MODE_READ,  8'h00, 11'd3,    1'b0, 11'd0,   8'h00, 8'h00, 1'b0},
		'{MODE_READ,  8'h00, 11'd4,    1'b1, 11'd5,   8'h0A, 8'h0F, 1'b0},
		'{MODE_PUT,   8'h0A, 11'd0,    1'b1, 11'd80,  8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h0D, 11'd0,    1'b1, 11'd160, 8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h41, 11'd0,    1'b0, 11'd0,   8'h00, 8'h00, 1'b0},
		'{MODE_PUT,   8'h0A, 11'd0,    1'b1, 11'd240, 8'h00, 8'h00, 1'b0},
		'{MODE_READ,  8'h00, 11'd160,  1'b0, 11'd0,   8'h00, 8'h00, 1'b0},
		'{MODE_CLEAR, 8'hFF, 11'h7FF,  1'b1, 11'd0,   8'h00, 8'h00, 1'b0},
		'{MODE_READ,  8'h00, 11'd160,  1'b1, 11'd0,   8'h00, 8'h0A, 1'b0},
		'{MODE_READ,  8'h00, 11'd1,    1'b1, 11'd0,   8'h00, 8'h0A, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// advance the shadow screen by one command, return the result it must give
	function automatic console_result_t console_step(input mode_t m, input logic [7:0] ch,
			input logic [10:0] idx);
		console_result_t r;
		r = '0;
		case (m)
			MODE_PUT, MODE_RAW: begin
				if (m == MODE_RAW || (ch >= CH_SPACE && ch <= CH_TILDE)) begin
					if (cursor_now < CELLS) begin
						screen_char[cursor_now] = ch;
						screen_attr[cursor_now] = attr_text;
					end
					cursor_now++;
				end else if (ch == CH_LF) begin
					cursor_now = cursor_now - cursor_now % COLUMNS + COLUMNS;
				end else if (ch == CH_CR) begin
					cursor_now += COLUMNS;
				end
				// past the last cell: move every row up and blank the bottom one
				if (cursor_now >= CELLS) begin
					for (int i = 0; i < CELLS; i++) begin
						screen_char[i] = (i < CELLS - COLUMNS) ? screen_char[i + COLUMNS] : 8'h00;
						screen_attr[i] = (i < CELLS - COLUMNS) ? screen_attr[i + COLUMNS] : attr_blank;
					end
					cursor_now -= COLUMNS;
					r.scrolled = 1'b1;
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen_char[i] = 8'h00;
					screen_attr[i] = attr_blank;
				end
				cursor_now = 0;
			end
			default: begin
				if (idx < CELLS) begin
					r.read_char = screen_char[idx];
					r.read_attr = screen_attr[idx];
				end
			end
		endcase
		r.cursor_pos = cursor_now[10:0];
		return r;
	endfunction

	// input-side gap: mostly none or short, now and then long, with calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		if (r < 2) send_calm = $urandom_range(40, 150);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// drive one beat, hold it until taken, then record what it must produce
	// s_tvalid is only lowered ahead of a gap so it never gets two updates in one step
	task automatic send_beat(input mode_t m, input logic [7:0] ch, input logic [10:0] idx,
			input bit typed, input console_result_t want);
		console_cmd_t    cmd;
		console_result_t got;
		int              gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.mode       = m;
		cmd.char_code  = ch;
		cmd.cell_index = idx;
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, cmd};
		do @(posedge clk); while (!s_tready);
		got = console_step(m, ch, idx);
		pending_results.push_back(typed ? want : got);
		beats_in++;
		if (got.scrolled) scroll_count++;
		if (m == MODE_CLEAR) clear_count++;
		if (m == MODE_READ) read_count++;
	endtask

	// hold off the input until every result is back and the block takes beats again
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0 || !s_tready);
		@(posedge clk);
	endtask

	// set both attributes on back-to-back cycles, block idle
	task automatic write_attrs(input logic [7:0] text_v, input logic [7:0] blank_v);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TEXT_ATTR;
		cfg_data  <= text_v;
		@(posedge clk);
		attr_text  = text_v;
		cfg_index <= REG_BLANK_ATTR;
		cfg_data  <= blank_v;
		@(posedge clk);
		attr_blank = blank_v;
		cfg_we    <= 1'b0;
	endtask

	// one random command; most are text, with reads aimed near the cursor
	task automatic send_random(inout int lf_run);
		int         r;
		int         lo;
		logic [7:0] ch;
		r  = $urandom_range(0, 999);
		ch = 8'($urandom_range(0, 255));
		if (lf_run > 0) begin
			lf_run--;
			send_beat(MODE_PUT, CH_LF, 11'($urandom_range(0, 2047)), 1'b0, '0);
		end else if (r < 490) begin
			send_beat(MODE_PUT, 8'($urandom_range(CH_SPACE, CH_TILDE)),
				11'($urandom_range(0, 2047)), 1'b0, '0);
		end else if (r < 540) begin
			send_beat(MODE_PUT, CH_LF, 11'($urandom_range(0, 2047)), 1'b0, '0);
		end else if (r < 565) begin
			send_beat(MODE_PUT, CH_CR, 11'($urandom_range(0, 2047)), 1'b0, '0);
		end else if (r < 575) begin
			// run of newlines down to the bottom row and up to two scrolls past it
			lf_run = (CELLS - cursor_now) / COLUMNS + $urandom_range(0, 1);
		end else if (r < 625) begin
			// control and high bytes other than LF and CR are dropped by the put path
			if (ch >= CH_SPACE && ch <= CH_TILDE) ch = ch ^ 8'h80;
			send_beat(MODE_PUT, ch, 11'($urandom_range(0, 2047)), 1'b0, '0);
		end else if (r < 750) begin
			send_beat(MODE_RAW, ch, 11'($urandom_range(0, 2047)), 1'b0, '0);
		end else if (r < 990) begin
			lo = (cursor_now > 160) ? cursor_now - 160 : 0;
			r  = $urandom_range(0, 9);
			if (r < 6)
				send_beat(MODE_READ, ch, 11'($urandom_range(lo, cursor_now)), 1'b0, '0);
			else if (r < 9)
				send_beat(MODE_READ, ch, 11'($urandom_range(0, CELLS - 1)), 1'b0, '0);
			else
				send_beat(MODE_READ, ch, 11'($urandom_range(CELLS, 2047)), 1'b0, '0);
		end else begin
			send_beat(MODE_CLEAR, ch, 11'($urandom_range(0, 2047)), 1'b0, '0);
		end
	endtask

	// output-side stalls: short ones mostly, a few long, and stall-free stretches
	always @(posedge clk) begin : ready_gen
		int r;
		int hold_left;
		int calm_left;
		if (hold_left > 0) begin
			hold_left--;
		end else if (calm_left > 0) begin
			calm_left--;
			m_tready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				calm_left = $urandom_range(50, 200);
				m_tready <= 1'b1;
			end else if (r < 60) begin
				m_tready <= 1'b1;
				hold_left = $urandom_range(0, 4);
			end else if (r < 95) begin
				m_tready <= 1'b0;
				hold_left = $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b0;
				hold_left = $urandom_range(10, 50);
			end
		end
	end

	// result checker: every accepted beat against the oldest expectation
	always @(posedge clk) begin : result_check
		console_result_t act;
		console_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			act = m_tdata[27:0];
			beats_out++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result beat %h at %0t", act, $realtime);
			end else begin
				want = pending_results.pop_front();
				if (act.cursor_pos !== want.cursor_pos || act.read_char !== want.read_char ||
						act.read_attr !== want.read_attr || act.scrolled !== want.scrolled) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("beat %0d: cursor %0d/%0d char %h/%h attr %h/%h scroll %b/%b (exp/act)",
							beats_out, want.cursor_pos, act.cursor_pos, want.read_char,
							act.read_char, want.read_attr, act.read_attr, want.scrolled,
							act.scrolled);
				end
			end
		end
	end

	// watchdog: too long with no beat moving on either side
	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results.size());
				$display("FAIL text_console_writer_core");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int         lf_run;
		logic [7:0] text_v;
		logic [7:0] blank_v;
		console_result_t typed_want;

		// shadow reset state: blank screen, cursor home, reset attributes
		for (int i = 0; i < CELLS; i++) begin
			screen_char[i] = 8'h00;
			screen_attr[i] = BLANK_ATTR_RESET;
		end
		cursor_now = 0;
		attr_text  = TEXT_ATTR_RESET;
		attr_blank = BLANK_ATTR_RESET;
		lf_run     = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; the clearing pass after reset holds s_tready low meanwhile
		foreach (directed_plan[k]) begin
			typed_want.cursor_pos = directed_plan[k].cur;
			typed_want.read_char  = directed_plan[k].rch;
			typed_want.read_attr  = directed_plan[k].rat;
			typed_want.scrolled   = directed_plan[k].scr;
			send_beat(directed_plan[k].mode, directed_plan[k].ch, directed_plan[k].idx,
				directed_plan[k].typed, typed_want);
		end

		// random phases, each under its own attribute setting: both extremes first
		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			case (p)
				0: begin text_v = 8'h00; blank_v = 8'hFF; end
				1: begin text_v = 8'hFF; blank_v = 8'h00; end
				default: begin
					text_v  = 8'($urandom_range(0, 255));
					blank_v = 8'($urandom_range(0, 255));
				end
			endcase
			write_attrs(text_v, blank_v);
			// a clear up front so the new blank attribute shows on the screen
			if (p == 0)
				send_beat(MODE_CLEAR, 8'h00, 11'd0, 1'b0, '0);
			for (int n = 0; n < PHASE_BEATS; n++)
				send_random(lf_run);
			while (lf_run > 0)
				send_random(lf_run);
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		// room for a stray beat behind a last scroll walk
		repeat (CELLS + 20) @(negedge clk);
		mismatches += pending_results.size();

		$display("run: %0d command beats, %0d results, %0d reads, %0d scrolls, %0d clears",
			beats_in, beats_out, read_count, scroll_count, clear_count);
		$display("run: %0d attribute settings incl. both extremes, %0d mismatches",
			PHASES + 1, mismatches);
		if (mismatches == 0)
			$display("PASS text_console_writer_core");
		else
			$display("FAIL text_console_writer_core");
		$finish;
	end

endmodule
